// ----- hdl/oate_pkg.sv -----
// oate_pkg: shared types and codes for the ordered array table engine
// field widths, operation and status codes, sequencer states, result struct
// no dependencies
`default_nettype none

package oate_pkg;

  localparam int OP_BITS     = 3;
  localparam int POS_BITS    = 7;
  localparam int DATA_BITS   = 32;
  localparam int STATUS_BITS = 3;
  localparam int FPOS_BITS   = 6;
  localparam int COUNT_BITS  = 7;

  // operation codes
  localparam logic [OP_BITS-1:0] OP_INSERT   = 3'd0;
  localparam logic [OP_BITS-1:0] OP_DELETE   = 3'd1;
  localparam logic [OP_BITS-1:0] OP_UPDATE   = 3'd2;
  localparam logic [OP_BITS-1:0] OP_SEARCH   = 3'd3;
  localparam logic [OP_BITS-1:0] OP_TRAVERSE = 3'd4;

  // status codes
  localparam logic [STATUS_BITS-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_BAD_INDEX = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY     = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_INS,
    S_DEL,
    S_SRCH,
    S_TRAV,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0]      status;
    logic [FPOS_BITS-1:0]        found_position;
    logic signed [DATA_BITS-1:0] read_word;
    logic                        last;
    logic [COUNT_BITS-1:0]       entry_count;
  } res_t;

endpackage

`default_nettype wire

// ----- hdl/oate_if.sv -----
// oate_req_if / oate_res_if: valid-ready channels for requests and results
// depends on oate_pkg for field widths
`default_nettype none

interface oate_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [oate_pkg::OP_BITS-1:0]         op;
  logic [oate_pkg::POS_BITS-1:0]        position;
  logic signed [oate_pkg::DATA_BITS-1:0] data_word;

  modport source (output valid, output op, output position, output data_word, input ready);
  modport sink   (input valid, input op, input position, input data_word, output ready);
endinterface

interface oate_res_if;
  logic                                   valid;
  logic                                   ready;
  logic [oate_pkg::STATUS_BITS-1:0]       status;
  logic [oate_pkg::FPOS_BITS-1:0]         found_position;
  logic signed [oate_pkg::DATA_BITS-1:0]  read_word;
  logic                                   last;
  logic [oate_pkg::COUNT_BITS-1:0]        entry_count;

  modport source (output valid, output status, output found_position, output read_word,
                  output last, output entry_count, input ready);
  modport sink   (input valid, input status, input found_position, input read_word,
                  input last, input entry_count, output ready);
endinterface

`default_nettype wire

// ----- hdl/oate_mem.sv -----
// oate_mem: entry storage, one write port and one registered read port
// read data holds while the read enable is low
`default_nettype none

module oate_mem #(
  parameter int DEPTH     = 64,
  parameter int WORD_BITS = 32,
  parameter int AW        = $clog2(DEPTH)
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [AW-1:0]        waddr,
  input  wire logic [WORD_BITS-1:0] wdata,
  input  wire logic                 re,
  input  wire logic [AW-1:0]        raddr,
  output logic      [WORD_BITS-1:0] rdata
);

  logic [WORD_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/oate_seq.sv -----
// oate_seq: request sequencer, walks the entry memory one address per cycle while no result waits on a stall
// depends on oate_pkg and oate_if; drives oate_mem and the result stage
`default_nettype none

module oate_seq #(
  parameter int DEPTH     = 64,
  parameter int WORD_BITS = 32,
  parameter int AW        = $clog2(DEPTH),
  parameter int CW        = $clog2(DEPTH + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  oate_req_if.sink                  req,
  output logic                      res_valid,
  input  wire logic                 res_ready,
  output oate_pkg::res_t            res,
  output logic                      mem_we,
  output logic [AW-1:0]             mem_waddr,
  output logic [WORD_BITS-1:0]      mem_wdata,
  output logic                      mem_re,
  output logic [AW-1:0]             mem_raddr,
  input  wire logic [WORD_BITS-1:0] mem_rdata
);

  localparam int PW = (CW > oate_pkg::POS_BITS) ? CW : oate_pkg::POS_BITS;

  oate_pkg::state_t state, state_next;

  logic [oate_pkg::OP_BITS-1:0]     op_q;
  logic [oate_pkg::POS_BITS-1:0]    pos_q;
  logic [WORD_BITS-1:0]             word_q;
  logic [CW-1:0]                    fill_count;
  logic [CW-1:0]                    idx;
  logic                             pend;
  logic [AW-1:0]                    pend_addr;
  logic [oate_pkg::STATUS_BITS-1:0] res_status;
  logic [AW-1:0]                    res_pos;
  logic [WORD_BITS-1:0]             res_word;

  logic [AW-1:0] pos_a;
  logic          pos_gt_cnt;
  logic          pos_ge_cnt;
  logic          is_full;
  logic          ins_more;
  logic          walk_more;
  logic          pend_hit;
  logic          last_elem;
  logic          trv_go;

  assign req.ready  = (state == oate_pkg::S_IDLE);
  assign pos_a      = AW'(pos_q);
  assign pos_gt_cnt = PW'(pos_q) > PW'(fill_count);
  assign pos_ge_cnt = PW'(pos_q) >= PW'(fill_count);
  assign is_full    = (fill_count == CW'(DEPTH));
  assign ins_more   = PW'(idx) > PW'(pos_q);
  assign walk_more  = idx < fill_count;
  assign pend_hit   = pend && (mem_rdata == word_q);
  assign last_elem  = (CW'(pend_addr) == fill_count - 1'b1);
  assign trv_go     = walk_more && (!pend || res_ready);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      oate_pkg::S_IDLE: begin
        if (req.valid) begin
          state_next = oate_pkg::S_DISPATCH;
        end
      end
      oate_pkg::S_DISPATCH: begin
        unique case (op_q)
          oate_pkg::OP_INSERT: begin
            state_next = (pos_gt_cnt || is_full) ? oate_pkg::S_EMIT : oate_pkg::S_INS;
          end
          oate_pkg::OP_DELETE: begin
            state_next = pos_ge_cnt ? oate_pkg::S_EMIT : oate_pkg::S_DEL;
          end
          oate_pkg::OP_UPDATE:   state_next = oate_pkg::S_EMIT;
          oate_pkg::OP_SEARCH:   state_next = oate_pkg::S_SRCH;
          oate_pkg::OP_TRAVERSE: begin
            state_next = (fill_count == '0) ? oate_pkg::S_EMIT : oate_pkg::S_TRAV;
          end
          default:               state_next = oate_pkg::S_IDLE;
        endcase
      end
      oate_pkg::S_INS: begin
        if (!ins_more && !pend) begin
          state_next = oate_pkg::S_EMIT;
        end
      end
      oate_pkg::S_DEL: begin
        if (!walk_more && !pend) begin
          state_next = oate_pkg::S_EMIT;
        end
      end
      oate_pkg::S_SRCH: begin
        if (pend_hit || (!walk_more && !pend)) begin
          state_next = oate_pkg::S_EMIT;
        end
      end
      oate_pkg::S_TRAV: begin
        if (pend && res_ready && last_elem) begin
          state_next = oate_pkg::S_IDLE;
        end
      end
      oate_pkg::S_EMIT: begin
        if (res_ready) begin
          state_next = oate_pkg::S_IDLE;
        end
      end
      default: state_next = oate_pkg::S_IDLE;
    endcase
  end

  // memory controls and result
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    res_valid = 1'b0;
    res       = '0;
    unique case (state)
      oate_pkg::S_DISPATCH: begin
        if (op_q == oate_pkg::OP_UPDATE && !pos_ge_cnt) begin
          mem_we    = 1'b1;
          mem_waddr = pos_a;
          mem_wdata = word_q;
        end
      end
      oate_pkg::S_INS: begin
        // move entries up, then drop the new word into the gap
        if (pend) begin
          mem_we    = 1'b1;
          mem_waddr = pend_addr;
          mem_wdata = mem_rdata;
        end else if (!ins_more) begin
          mem_we    = 1'b1;
          mem_waddr = pos_a;
          mem_wdata = word_q;
        end
        if (ins_more) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(idx - 1'b1);
        end
      end
      oate_pkg::S_DEL: begin
        // first read is the removed entry, later ones move down
        if (pend && pend_addr != pos_a) begin
          mem_we    = 1'b1;
          mem_waddr = pend_addr - 1'b1;
          mem_wdata = mem_rdata;
        end
        if (walk_more) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(idx);
        end
      end
      oate_pkg::S_SRCH: begin
        if (walk_more && !pend_hit) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(idx);
        end
      end
      oate_pkg::S_TRAV: begin
        if (trv_go) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(idx);
        end
        res_valid          = pend;
        res.status         = oate_pkg::ST_OK;
        res.found_position = oate_pkg::FPOS_BITS'(pend_addr);
        res.read_word      = $signed(oate_pkg::DATA_BITS'(mem_rdata));
        res.last           = last_elem;
        res.entry_count    = oate_pkg::COUNT_BITS'(fill_count);
      end
      oate_pkg::S_EMIT: begin
        res_valid          = 1'b1;
        res.status         = res_status;
        res.found_position = oate_pkg::FPOS_BITS'(res_pos);
        res.read_word      = $signed(oate_pkg::DATA_BITS'(res_word));
        res.last           = 1'b1;
        res.entry_count    = oate_pkg::COUNT_BITS'(fill_count);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= oate_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      pend       <= 1'b0;
    end else begin
      unique case (state)
        oate_pkg::S_IDLE: begin
          if (req.valid) begin
            op_q   <= req.op;
            pos_q  <= req.position;
            word_q <= WORD_BITS'($unsigned(req.data_word));
          end
        end
        oate_pkg::S_DISPATCH: begin
          pend       <= 1'b0;
          res_status <= oate_pkg::ST_BAD_INDEX;
          res_pos    <= '0;
          res_word   <= '0;
          unique case (op_q)
            oate_pkg::OP_INSERT: begin
              idx <= fill_count;
              if (!pos_gt_cnt && is_full) begin
                res_status <= oate_pkg::ST_FULL;
              end
            end
            oate_pkg::OP_DELETE: idx <= CW'(pos_q);
            oate_pkg::OP_UPDATE: begin
              if (!pos_ge_cnt) begin
                res_status <= oate_pkg::ST_OK;
                res_pos    <= pos_a;
                res_word   <= word_q;
              end
            end
            oate_pkg::OP_SEARCH: idx <= '0;
            oate_pkg::OP_TRAVERSE: begin
              idx        <= '0;
              res_status <= oate_pkg::ST_EMPTY;
            end
            default: begin
            end
          endcase
        end
        oate_pkg::S_INS: begin
          if (ins_more) begin
            idx       <= idx - 1'b1;
            pend      <= 1'b1;
            pend_addr <= AW'(idx);
          end else begin
            pend <= 1'b0;
          end
          if (!ins_more && !pend) begin
            fill_count <= fill_count + 1'b1;
            res_status <= oate_pkg::ST_OK;
            res_pos    <= pos_a;
            res_word   <= word_q;
          end
        end
        oate_pkg::S_DEL: begin
          if (walk_more) begin
            idx       <= idx + 1'b1;
            pend      <= 1'b1;
            pend_addr <= AW'(idx);
          end else begin
            pend <= 1'b0;
          end
          if (pend && pend_addr == pos_a) begin
            res_word <= mem_rdata;
          end
          if (!walk_more && !pend) begin
            fill_count <= fill_count - 1'b1;
            res_status <= oate_pkg::ST_OK;
            res_pos    <= pos_a;
          end
        end
        oate_pkg::S_SRCH: begin
          if (pend_hit) begin
            res_status <= oate_pkg::ST_OK;
            res_pos    <= pend_addr;
            res_word   <= mem_rdata;
          end else if (walk_more) begin
            idx       <= idx + 1'b1;
            pend      <= 1'b1;
            pend_addr <= AW'(idx);
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              res_status <= oate_pkg::ST_NOT_FOUND;
            end
          end
        end
        oate_pkg::S_TRAV: begin
          if (trv_go) begin
            idx       <= idx + 1'b1;
            pend      <= 1'b1;
            pend_addr <= AW'(idx);
          end else if (pend && res_ready) begin
            pend <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTH
  a_count_moves_only_in_shift: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && fill_count != $past(fill_count)) |->
      ($past(state) == oate_pkg::S_INS || $past(state) == oate_pkg::S_DEL))
    else $error("entry count changed outside insert or delete");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CW'(DEPTH))
    else $error("entry count above depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (state == oate_pkg::S_INS && state_next == oate_pkg::S_EMIT) |=>
      (fill_count == $past(fill_count) + 1'b1))
    else $error("insert did not grow the count by one");

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == oate_pkg::S_DISPATCH || state == oate_pkg::S_INS ||
                state == oate_pkg::S_DEL))
    else $error("memory written outside update, insert or delete");

  a_no_result_when_idle: assert property (@(posedge clk) disable iff (rst)
    (state == oate_pkg::S_IDLE || state == oate_pkg::S_DISPATCH) |-> !res_valid)
    else $error("result offered while no request is in progress");
`endif

endmodule

`default_nettype wire

// ----- hdl/ordered_array_table_engine_top.sv -----
// ordered_array_table_engine_top: dense array of signed words with a count
//
// req channel (valid/ready) carries op, position and data_word; rsp channel
// carries status, found_position, read_word, last and entry_count. An item is
// taken when valid and ready are high at a clock edge. One request is worked
// at a time: req.ready is high only while the sequencer is idle.
// Insert moves the entries from the position to the end up by one, delete
// moves the entries after the position down by one, search reads from index
// 0 to the first hit or to the end; update, a rejected request and traverse
// of an empty array give their result without a walk; unknown ops give none.
// Traverse gives one result per entry, one per cycle while rsp.ready stays
// high, the last one marked. Another request is taken the cycle after the
// final result leaves the sequencer. The sequencer moves one entry per cycle
// while no result waits on a stall, through the single read and single write
// port of the entry memory, so the length of the walk sets each request's time.
// Results pass through an output register; a stall on rsp holds that register
// and holds the sequencer once it has a result to give, no result is dropped.
// Synchronous reset empties the array (count to zero) and returns to idle.
// depends on oate_pkg, oate_if, oate_mem, oate_seq
`default_nettype none

module ordered_array_table_engine_top #(
  parameter int DEPTH     = 64,
  parameter int WORD_BITS = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  oate_req_if.sink  req,
  oate_res_if.source rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;
  logic [WORD_BITS-1:0] mem_rdata;

  logic           res_valid;
  logic           res_ready;
  oate_pkg::res_t res;

  logic           out_valid;
  oate_pkg::res_t out_data;

  oate_mem #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS),
    .AW        (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  oate_seq #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS),
    .AW        (AW),
    .CW        (CW)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // output register
  assign res_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data <= res;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_data.status;
  assign rsp.found_position = out_data.found_position;
  assign rsp.read_word      = out_data.read_word;
  assign rsp.last           = out_data.last;
  assign rsp.entry_count    = out_data.entry_count;

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// tb_top: self-checking testbench for ordered_array_table_engine_top
// drives requests over oate_req_if, checks results on oate_res_if against an internal table model
// depends on oate_pkg, oate_if and the engine rtl
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH  = 64;
  localparam int QUIET_LIMIT  = 1000;
  localparam int SETTLE_WAIT  = 100;

  // op codes outside the defined set, the engine drops them
  localparam logic [oate_pkg::OP_BITS-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [oate_pkg::OP_BITS-1:0] OP_SPARE_MID   = 3'd6;
  localparam logic [oate_pkg::OP_BITS-1:0] OP_SPARE_LAST  = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;

  oate_req_if req_ch ();
  oate_res_if rsp_ch ();

  ordered_array_table_engine_top #(
    .DEPTH     (TABLE_DEPTH),
    .WORD_BITS (oate_pkg::DATA_BITS)
  ) uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // table model
  logic signed [oate_pkg::DATA_BITS-1:0] model_words [TABLE_DEPTH];
  int                                    model_count = 0;
  oate_pkg::res_t                        pending_results [$];
  oate_pkg::res_t                        oldest_result;
  int                                    mismatches  = 0;
  int                                    burst_left  = 0;
  int                                    ready_hold  = 0;
  int                                    quiet_cycles = 0;

  function automatic void queue_result(logic [oate_pkg::STATUS_BITS-1:0] status, int fpos,
                                       logic signed [oate_pkg::DATA_BITS-1:0] word,
                                       logic last);
    oate_pkg::res_t r;
    r.status         = status;
    r.found_position = fpos[oate_pkg::FPOS_BITS-1:0];
    r.read_word      = word;
    r.last           = last;
    r.entry_count    = model_count[oate_pkg::COUNT_BITS-1:0];
    pending_results.push_back(r);
  endfunction

  function automatic void predict_table_op(logic [oate_pkg::OP_BITS-1:0] op,
                                           logic [oate_pkg::POS_BITS-1:0] pos,
                                           logic signed [oate_pkg::DATA_BITS-1:0] word);
    int                                    idx;
    int                                    p;
    logic signed [oate_pkg::DATA_BITS-1:0] removed;
    p = int'(pos);
    case (op)
      oate_pkg::OP_INSERT: begin
        // index is checked before capacity
        if (p > model_count) begin
          queue_result(oate_pkg::ST_BAD_INDEX, 0, '0, 1'b1);
        end else if (model_count >= TABLE_DEPTH) begin
          queue_result(oate_pkg::ST_FULL, 0, '0, 1'b1);
        end else begin
          for (idx = model_count; idx > p; idx--) model_words[idx] = model_words[idx-1];
          model_words[p] = word;
          model_count++;
          queue_result(oate_pkg::ST_OK, p, word, 1'b1);
        end
      end
      oate_pkg::OP_DELETE: begin
        if (p >= model_count) begin
          queue_result(oate_pkg::ST_BAD_INDEX, 0, '0, 1'b1);
        end else begin
          removed = model_words[p];
          for (idx = p; idx + 1 < model_count; idx++) model_words[idx] = model_words[idx+1];
          model_count--;
          queue_result(oate_pkg::ST_OK, p, removed, 1'b1);
        end
      end
      oate_pkg::OP_UPDATE: begin
        if (p >= model_count) begin
          queue_result(oate_pkg::ST_BAD_INDEX, 0, '0, 1'b1);
        end else begin
          model_words[p] = word;
          queue_result(oate_pkg::ST_OK, p, word, 1'b1);
        end
      end
      oate_pkg::OP_SEARCH: begin
        for (idx = 0; idx < model_count; idx++) begin
          if (model_words[idx] == word) break;
        end
        if (idx < model_count) queue_result(oate_pkg::ST_OK, idx, model_words[idx], 1'b1);
        else queue_result(oate_pkg::ST_NOT_FOUND, 0, '0, 1'b1);
      end
      oate_pkg::OP_TRAVERSE: begin
        if (model_count == 0) begin
          queue_result(oate_pkg::ST_EMPTY, 0, '0, 1'b1);
        end else begin
          for (idx = 0; idx < model_count; idx++)
            queue_result(oate_pkg::ST_OK, idx, model_words[idx], idx + 1 == model_count);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic signed [oate_pkg::DATA_BITS-1:0] pick_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'sh8000_0000;
    if (r == 1) return 32'sh7fff_ffff;
    // small values give duplicates for search
    if (r < 4) return $signed(oate_pkg::DATA_BITS'($urandom_range(0, 7)));
    return $signed(oate_pkg::DATA_BITS'($urandom));
  endfunction

  // sender: bursts of items with random gaps between them
  task automatic send_request(logic [oate_pkg::OP_BITS-1:0] op,
                              logic [oate_pkg::POS_BITS-1:0] pos,
                              logic signed [oate_pkg::DATA_BITS-1:0] word);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    req_ch.valid     <= 1'b1;
    req_ch.op        <= op;
    req_ch.position  <= pos;
    req_ch.data_word <= word;
    do @(posedge clk); while (!req_ch.ready);
    burst_left--;
    predict_table_op(op, pos, word);
  endtask

  task automatic finish_traffic();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic random_requests(int n, int w_ins, int w_del, int w_upd, int w_srch,
                                 int w_trav);
    int                                    r;
    logic [oate_pkg::OP_BITS-1:0]          op;
    logic [oate_pkg::POS_BITS-1:0]         pos;
    logic signed [oate_pkg::DATA_BITS-1:0] word;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < w_ins) op = oate_pkg::OP_INSERT;
      else if (r < w_ins + w_del) op = oate_pkg::OP_DELETE;
      else if (r < w_ins + w_del + w_upd) op = oate_pkg::OP_UPDATE;
      else if (r < w_ins + w_del + w_upd + w_srch) op = oate_pkg::OP_SEARCH;
      else if (r < w_ins + w_del + w_upd + w_srch + w_trav) op = oate_pkg::OP_TRAVERSE;
      else op = oate_pkg::OP_BITS'($urandom_range(int'(OP_SPARE_FIRST),
                                                  int'(OP_SPARE_LAST)));
      word = pick_word();
      pos  = oate_pkg::POS_BITS'($urandom_range(0, 127));
      // mostly in-range positions, the rest anywhere in the field
      if ($urandom_range(0, 99) < 85) begin
        if (op == oate_pkg::OP_INSERT) begin
          pos = oate_pkg::POS_BITS'($urandom_range(0, model_count));
        end else if (model_count > 0) begin
          pos = oate_pkg::POS_BITS'($urandom_range(0, model_count - 1));
        end
      end
      if (op == oate_pkg::OP_SEARCH && model_count > 0 && $urandom_range(0, 9) < 6)
        word = model_words[$urandom_range(0, model_count - 1)];
      send_request(op, pos, word);
    end
  endtask

  task automatic test_directed_cases();
    // empty table
    send_request(oate_pkg::OP_TRAVERSE, 7'd0, pick_word());
    send_request(oate_pkg::OP_SEARCH, 7'd0, 32'sd0);
    send_request(oate_pkg::OP_DELETE, 7'd0, pick_word());
    send_request(oate_pkg::OP_UPDATE, 7'd0, pick_word());
    send_request(oate_pkg::OP_INSERT, 7'd1, pick_word());
    send_request(oate_pkg::OP_INSERT, 7'd127, 32'sh7fff_ffff);
    send_request(OP_SPARE_FIRST, 7'd0, pick_word());
    send_request(OP_SPARE_MID, 7'd64, pick_word());
    send_request(OP_SPARE_LAST, 7'd127, 32'sh8000_0000);
    // build a short table at end, front and middle
    send_request(oate_pkg::OP_INSERT, 7'd0, 32'sh8000_0000);
    send_request(oate_pkg::OP_INSERT, 7'd1, 32'sh7fff_ffff);
    send_request(oate_pkg::OP_INSERT, 7'd0, -32'sd1);
    send_request(oate_pkg::OP_INSERT, 7'd1, 32'sd5);
    send_request(oate_pkg::OP_INSERT, 7'd4, 32'sd5);
    // first of two equal entries wins
    send_request(oate_pkg::OP_SEARCH, 7'd0, 32'sd5);
    send_request(oate_pkg::OP_SEARCH, 7'd0, 32'sh7fff_ffff);
    send_request(oate_pkg::OP_SEARCH, 7'd0, 32'sd12345);
    send_request(oate_pkg::OP_UPDATE, 7'd3, 32'sd0);
    send_request(oate_pkg::OP_UPDATE, 7'd5, pick_word());
    send_request(oate_pkg::OP_DELETE, 7'd5, pick_word());
    send_request(oate_pkg::OP_DELETE, 7'd0, pick_word());
    send_request(oate_pkg::OP_DELETE, 7'd3, pick_word());
    send_request(oate_pkg::OP_DELETE, 7'd1, pick_word());
    send_request(oate_pkg::OP_TRAVERSE, 7'd0, pick_word());
    send_request(oate_pkg::OP_DELETE, 7'd64, pick_word());
  endtask

  task automatic test_capacity();
    // load by inserts at the end until full
    while (model_count < TABLE_DEPTH)
      send_request(oate_pkg::OP_INSERT, oate_pkg::POS_BITS'(model_count), pick_word());
    send_request(oate_pkg::OP_INSERT, oate_pkg::POS_BITS'(TABLE_DEPTH), pick_word());
    send_request(oate_pkg::OP_INSERT, 7'd0, pick_word());
    send_request(oate_pkg::OP_INSERT, oate_pkg::POS_BITS'(TABLE_DEPTH + 1), pick_word());
    send_request(oate_pkg::OP_TRAVERSE, 7'd0, pick_word());
    send_request(oate_pkg::OP_SEARCH, 7'd0, model_words[TABLE_DEPTH-1]);
    send_request(oate_pkg::OP_UPDATE, oate_pkg::POS_BITS'(TABLE_DEPTH - 1), pick_word());
    send_request(oate_pkg::OP_DELETE, oate_pkg::POS_BITS'(TABLE_DEPTH), pick_word());
    send_request(oate_pkg::OP_DELETE, oate_pkg::POS_BITS'(TABLE_DEPTH - 1), pick_word());
  endtask

  task automatic test_churn_near_full();
    random_requests(60, 45, 20, 10, 15, 5);
  endtask

  task automatic test_shrink();
    random_requests(80, 10, 60, 10, 12, 5);
  endtask

  task automatic test_mixed();
    random_requests(45, 30, 28, 15, 17, 6);
  endtask

  // result checker and receiver stall pattern
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result item: status %0d pos %0d word %0d", rsp_ch.status,
               rsp_ch.found_position, rsp_ch.read_word);
        mismatches++;
      end else begin
        oldest_result = pending_results.pop_front();
        if (rsp_ch.status !== oldest_result.status) begin
          $error("status: expected %0d, got %0d", oldest_result.status, rsp_ch.status);
          mismatches++;
        end
        if (rsp_ch.found_position !== oldest_result.found_position) begin
          $error("found_position: expected %0d, got %0d", oldest_result.found_position,
                 rsp_ch.found_position);
          mismatches++;
        end
        if (rsp_ch.read_word !== oldest_result.read_word) begin
          $error("read_word: expected %0d, got %0d", oldest_result.read_word,
                 rsp_ch.read_word);
          mismatches++;
        end
        if (rsp_ch.last !== oldest_result.last) begin
          $error("last: expected %0d, got %0d", oldest_result.last, rsp_ch.last);
          mismatches++;
        end
        if (rsp_ch.entry_count !== oldest_result.entry_count) begin
          $error("entry_count: expected %0d, got %0d", oldest_result.entry_count,
                 rsp_ch.entry_count);
          mismatches++;
        end
      end
    end
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      ready_hold = 0;
    end else if (ready_hold == 0) begin
      if (rsp_ch.ready) begin
        rsp_ch.ready <= 1'b0;
        ready_hold = $urandom_range(0, 4);
      end else begin
        rsp_ch.ready <= 1'b1;
        // now and then a long stretch with no stalls
        ready_hold = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(0, 16);
      end
    end else begin
      ready_hold--;
    end
  end

  // watchdog on cycles with no item moving
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    req_ch.valid     <= 1'b0;
    req_ch.op        <= oate_pkg::OP_INSERT;
    req_ch.position  <= '0;
    req_ch.data_word <= '0;
    foreach (model_words[i]) model_words[i] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_capacity();
    test_churn_near_full();
    test_shrink();
    test_mixed();
    finish_traffic();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
hdl/oate_pkg.sv
hdl/oate_if.sv
hdl/oate_mem.sv
hdl/oate_seq.sv
hdl/ordered_array_table_engine_top.sv
tb/sv/tb_top.sv
